>>> rtl/pmvp_pkg.sv
// ----------------------------------------------------------------------------
// pmvp_pkg: shared definitions for the projection matrix-vector product
// Field widths, command and register codes, the queued item type, the
// back-end state type and the fixed-point rounding limits.
// ----------------------------------------------------------------------------
package pmvp_pkg;

    localparam int MAX_ROWS_DEFAULT = 8;
    localparam int MAX_COLS_DEFAULT = 16;

    localparam int ROW_W       = 3;
    localparam int COL_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int ROWS_REG_W  = 4;
    localparam int COLS_REG_W  = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int ACC_W       = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic CMD_COEF = 1'b0;
    localparam logic CMD_ELEM = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_ACC,
        OP_ACC_EMIT
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN,
        BK_EMIT
    } back_state_t;

    // Row sums at or above SUM_HI, or below SUM_LO, clip after rounding.
    localparam logic signed [ACC_W-1:0] SUM_HI     = 64'sh0000_7FFF_FFFF_8000;
    localparam logic signed [ACC_W-1:0] SUM_LO     = 64'shFFFF_7FFF_FFFF_8000;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sh0000_0000_0000_8000;
    localparam logic signed [VALUE_W-1:0] OUT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] OUT_MIN  = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0] ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN    = 64'sh8000_0000_0000_0000;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] full;
        full = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (full[ACC_W:ACC_W-1] == 2'b01)
        begin
            return ACC_MAX;
        end
        else if (full[ACC_W:ACC_W-1] == 2'b10)
        begin
            return ACC_MIN;
        end
        return full[ACC_W-1:0];
    endfunction

endpackage

>>> rtl/pmvp_in_if.sv
// ----------------------------------------------------------------------------
// pmvp_in_if: input item channel
// Valid/ready channel carrying one coefficient write or one vector element.
// ----------------------------------------------------------------------------
interface pmvp_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [pmvp_pkg::ROW_W-1:0]          row;
    logic [pmvp_pkg::COL_W-1:0]          col;
    logic signed [pmvp_pkg::VALUE_W-1:0] value;

    modport source (output valid, cmd, row, col, value, input ready);
    modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

>>> rtl/pmvp_out_if.sv
// ----------------------------------------------------------------------------
// pmvp_out_if: result channel
// Valid/ready channel carrying one projected row value per transfer.
// ----------------------------------------------------------------------------
interface pmvp_out_if;
    logic                                valid;
    logic                                ready;
    logic [pmvp_pkg::ROW_W-1:0]          out_row;
    logic signed [pmvp_pkg::VALUE_W-1:0] out_value;
    logic                                saturated;
    logic                                last;

    modport source (output valid, out_row, out_value, saturated, last, input ready);
    modport sink   (input valid, out_row, out_value, saturated, last, output ready);
endinterface

>>> rtl/projection_matrix_vector_product.sv
// ----------------------------------------------------------------------------
// projection_matrix_vector_product: Q16.16 matrix-vector projection
// A coefficient write is executed in the back end after the queue.
// A vector element is handled by the one shared multiply-accumulate, which
// visits each row in use in turn behind a registered read.
// An element that closes a vector then emits one result per row.
// Reset clears the row sums and sets both registers to one; the coefficient
// table is undefined until written.
// ----------------------------------------------------------------------------
module projection_matrix_vector_product #(
    parameter int MAX_ROWS = pmvp_pkg::MAX_ROWS_DEFAULT,
    parameter int MAX_COLS = pmvp_pkg::MAX_COLS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pmvp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmvp_pkg::CFG_DATA_W-1:0]  cfg_data,
    pmvp_in_if.sink                          vec,
    pmvp_out_if.source                       res
);
    import pmvp_pkg::*;

    logic                  push, pop, full, empty;
    item_t                 push_item, head_item;
    logic [ROWS_REG_W-1:0] rows_in_use;

    pmvp_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .vec         (vec),
        .full        (full),
        .push        (push),
        .push_item   (push_item),
        .rows_in_use (rows_in_use)
    );

    pmvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (full),
        .empty     (empty)
    );

    pmvp_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_item   (head_item),
        .empty       (empty),
        .pop         (pop),
        .rows_in_use (rows_in_use),
        .res         (res)
    );

endmodule

>>> rtl/pmvp_front.sv
// ----------------------------------------------------------------------------
// pmvp_front: input acceptance and classification
// Holds the configuration registers, accepts input transfers and turns each
// into a queued operation, dropping items that fall outside the table or
// beyond the columns in use.
// ----------------------------------------------------------------------------
module pmvp_front #(
    parameter int MAX_ROWS = pmvp_pkg::MAX_ROWS_DEFAULT,
    parameter int MAX_COLS = pmvp_pkg::MAX_COLS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pmvp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pmvp_pkg::CFG_DATA_W-1:0]      cfg_data,
    pmvp_in_if.sink                              vec,
    input  logic                                 full,
    output logic                                 push,
    output pmvp_pkg::item_t                      push_item,
    output logic [pmvp_pkg::ROWS_REG_W-1:0]      rows_in_use
);
    import pmvp_pkg::*;

    localparam int ROWS_CAP = (MAX_ROWS > 15) ? 15 : MAX_ROWS;
    localparam int COLS_CAP = (MAX_COLS > 31) ? 31 : MAX_COLS;

    logic [ROWS_REG_W-1:0] rows_reg, rows_next;
    logic [COLS_REG_W-1:0] cols_reg, cols_next;
    logic [ROWS_REG_W-1:0] rows_wr;
    logic [COLS_REG_W-1:0] cols_wr;
    logic                  keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_REG_W'(1);
            cols_reg <= COLS_REG_W'(1);
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    always_comb
    begin
        rows_wr = cfg_data[ROWS_REG_W-1:0];
        if (rows_wr == '0)
        begin
            rows_wr = ROWS_REG_W'(1);
        end
        else if (32'(rows_wr) > ROWS_CAP)
        begin
            rows_wr = ROWS_REG_W'(ROWS_CAP);
        end

        cols_wr = cfg_data[COLS_REG_W-1:0];
        if (cols_wr == '0)
        begin
            cols_wr = COLS_REG_W'(1);
        end
        else if (32'(cols_wr) > COLS_CAP)
        begin
            cols_wr = COLS_REG_W'(COLS_CAP);
        end

        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_we && cfg_index == REG_ROWS_IN_USE)
        begin
            rows_next = rows_wr;
        end
        if (cfg_we && cfg_index == REG_COLS_IN_USE)
        begin
            cols_next = cols_wr;
        end
    end

    always_comb
    begin
        push_item.row   = vec.row;
        push_item.col   = vec.col;
        push_item.value = vec.value;
        push_item.op    = OP_WRITE;
        keep            = 1'b0;
        unique case (vec.cmd)
            CMD_COEF:
            begin
                keep = (32'(vec.row) < MAX_ROWS) && (32'(vec.col) < MAX_COLS);
            end
            CMD_ELEM:
            begin
                keep = ({1'b0, vec.col} < cols_reg) && (32'(vec.col) < MAX_COLS);
                push_item.op = (COLS_REG_W'(vec.col) + COLS_REG_W'(1) == cols_reg)
                               ? OP_ACC_EMIT : OP_ACC;
            end
        endcase
    end

    assign vec.ready   = !full;
    assign push        = vec.valid && !full && keep;
    assign rows_in_use = rows_reg;

endmodule

>>> rtl/pmvp_queue.sv
// ----------------------------------------------------------------------------
// pmvp_queue: operation queue between front and back
// A small first-in first-out buffer of classified operations.
// ----------------------------------------------------------------------------
module pmvp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pmvp_pkg::item_t push_item,
    input  logic            pop,
    output pmvp_pkg::item_t head_item,
    output logic            full,
    output logic            empty
);
    import pmvp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (32'(count_reg) == QUEUE_DEPTH);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = slot_reg[rd_ptr_reg];

endmodule

>>> rtl/pmvp_back.sv
// ----------------------------------------------------------------------------
// pmvp_back: coefficient table and shared multiply-accumulate
// Executes queued operations: writes coefficients, runs one multiply and
// saturating accumulate per row in use, and after a vector's last element
// rounds, saturates and emits each row sum through a registered output.
// ----------------------------------------------------------------------------
module pmvp_back #(
    parameter int MAX_ROWS = pmvp_pkg::MAX_ROWS_DEFAULT,
    parameter int MAX_COLS = pmvp_pkg::MAX_COLS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pmvp_pkg::item_t                 head_item,
    input  logic                            empty,
    output logic                            pop,
    input  logic [pmvp_pkg::ROWS_REG_W-1:0] rows_in_use,
    pmvp_out_if.source                      res
);
    import pmvp_pkg::*;

    localparam int TABLE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    back_state_t               state_reg, state_next;
    logic [RW-1:0]             row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      emit_reg, emit_next;

    logic signed [VALUE_W-1:0] coef_mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] coef_rd_reg;
    logic [ADDR_W-1:0]         wr_addr, rd_addr;
    logic                      mem_we;

    logic                      s1_valid_reg, s2_valid_reg;
    logic [RW-1:0]             s1_row_reg, s2_row_reg;
    logic signed [ACC_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]   sum_reg [MAX_ROWS];

    logic                      issue, load_out, clear_sums, row_is_last;
    logic signed [ACC_W-1:0]   emit_sum, round_sum;
    logic signed [VALUE_W-1:0] out_value_next;
    logic                      sat_next;

    logic                      out_valid_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      sat_reg, last_reg;

    assign row_is_last = (32'(row_cnt_reg) + 32'd1 == 32'(rows_in_use));
    assign wr_addr     = ADDR_W'(32'(head_item.row) * MAX_COLS + 32'(head_item.col));
    assign rd_addr     = ADDR_W'(32'(row_cnt_reg) * MAX_COLS + 32'(col_reg));

    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        col_next     = col_reg;
        value_next   = value_reg;
        emit_next    = emit_reg;
        pop          = 1'b0;
        mem_we       = 1'b0;
        issue        = 1'b0;
        load_out     = 1'b0;
        clear_sums   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head_item.op == OP_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        col_next     = head_item.col;
                        value_next   = head_item.value;
                        emit_next    = (head_item.op == OP_ACC_EMIT);
                        row_cnt_next = '0;
                        state_next   = BK_ISSUE;
                    end
                end
            end
            BK_ISSUE:
            begin
                issue = 1'b1;
                if (row_is_last)
                begin
                    state_next = BK_DRAIN;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + RW'(1);
                end
            end
            BK_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    row_cnt_next = '0;
                    state_next   = emit_reg ? BK_EMIT : BK_IDLE;
                end
            end
            BK_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out = 1'b1;
                    if (row_is_last)
                    begin
                        clear_sums = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + RW'(1);
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_cnt_reg  <= row_cnt_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        value_reg  <= value_next;
        emit_reg   <= emit_next;
        s1_row_reg <= row_cnt_reg;
        s2_row_reg <= s1_row_reg;
        prod_reg   <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            coef_mem[wr_addr] <= head_item.value;
        end
        coef_rd_reg <= coef_mem[rd_addr];
    end

    assign prod_next = value_reg * coef_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (clear_sums)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (s2_valid_reg)
        begin
            sum_reg[s2_row_reg] <= sat_add(sum_reg[s2_row_reg], prod_reg);
        end
    end

    assign emit_sum  = sum_reg[row_cnt_reg];
    assign round_sum = emit_sum + ROUND_HALF;

    always_comb
    begin
        priority if (emit_sum >= SUM_HI)
        begin
            out_value_next = OUT_MAX;
            sat_next       = 1'b1;
        end
        else if (emit_sum < SUM_LO)
        begin
            out_value_next = OUT_MIN;
            sat_next       = 1'b1;
        end
        else
        begin
            out_value_next = round_sum[47:16];
            sat_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg   <= ROW_W'(row_cnt_reg);
            out_value_reg <= out_value_next;
            sat_reg       <= sat_next;
            last_reg      <= row_is_last;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_row   = out_row_reg;
    assign res.out_value = out_value_reg;
    assign res.saturated = sat_reg;
    assign res.last      = last_reg;

endmodule
